[design/date_add_subtract_days_assert.svh]
// Assertion macros for the date add/subtract block.
// Used by date_add_subtract_days.sv; expects clk_i and rst_ni in scope.
`ifndef DATE_ADD_SUBTRACT_DAYS_ASSERT_SVH
`define DATE_ADD_SUBTRACT_DAYS_ASSERT_SVH

// Check a property outside of reset.
`define DASD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every edge, reset included.
`define DASD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/dasd_pkg.sv]
// Package for the date add/subtract block: widths, month lengths, leap rule,
// and the microcode program of the sequencer. No dependencies.
package dasd_pkg;

  localparam int unsigned OFFSET_BITS = 16;
  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned D_W         = OFFSET_BITS + 2;
  localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(9999);

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_DATE  = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  // Months
  localparam logic [3:0] MON_JAN = 4'd1;
  localparam logic [3:0] MON_DEC = 4'd12;

  // Year position within the 400-year cycle
  localparam logic [YEAR_W-1:0] CYCLE_LEN  = YEAR_W'(400);
  localparam logic [YEAR_W-1:0] CYCLE_LAST = YEAR_W'(399);

  // Program steps
  typedef logic [2:0] step_t;
  localparam step_t S_IDLE   = 3'd0;
  localparam step_t S_REDUCE = 3'd1;
  localparam step_t S_CHECK  = 3'd2;
  localparam step_t S_PREP   = 3'd3;
  localparam step_t S_ADD    = 3'd4;
  localparam step_t S_SUB    = 3'd5;
  localparam step_t S_FINISH = 3'd6;

  typedef enum logic [2:0] {
    A_NONE,
    A_LOAD,
    A_REDUCE,
    A_CHECK,
    A_PREP,
    A_ADD_STEP,
    A_SUB_STEP,
    A_EMIT
  } act_e;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_NO_INPUT,
    C_CYCLE_DONE,
    C_INVALID,
    C_SUB,
    C_ADD_EXIT,
    C_SUB_EXIT,
    C_OUT_FULL
  } cond_e;

  // One control word: action, jump condition, jump target, else-target
  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t tgt;
    step_t nxt;
  } ucode_t;

  // Control store
  function automatic ucode_t ucode_rom(input step_t pc);
    ucode_t w;
    case (pc)
      S_IDLE:   w = '{act: A_LOAD,     cond: C_NO_INPUT,   tgt: S_IDLE,   nxt: S_REDUCE};
      S_REDUCE: w = '{act: A_REDUCE,   cond: C_CYCLE_DONE, tgt: S_CHECK,  nxt: S_REDUCE};
      S_CHECK:  w = '{act: A_CHECK,    cond: C_INVALID,    tgt: S_FINISH, nxt: S_PREP};
      S_PREP:   w = '{act: A_PREP,     cond: C_SUB,        tgt: S_SUB,    nxt: S_ADD};
      S_ADD:    w = '{act: A_ADD_STEP, cond: C_ADD_EXIT,   tgt: S_FINISH, nxt: S_ADD};
      S_SUB:    w = '{act: A_SUB_STEP, cond: C_SUB_EXIT,   tgt: S_FINISH, nxt: S_SUB};
      S_FINISH: w = '{act: A_EMIT,     cond: C_OUT_FULL,   tgt: S_FINISH, nxt: S_IDLE};
      default:  w = '{act: A_NONE,     cond: C_ALWAYS,     tgt: S_IDLE,   nxt: S_IDLE};
    endcase
    return w;
  endfunction

  // Gregorian leap rule from the year's position in the 400-year cycle
  function automatic logic is_leap(input logic [8:0] ycyc);
    return (ycyc[1:0] == 2'd0) &&
           (ycyc != 9'd100) && (ycyc != 9'd200) && (ycyc != 9'd300);
  endfunction

  // Month length; zero for a month code outside 1..12
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = leap ? 5'd29 : 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

[design/date_add_subtract_days.sv]
// Gregorian date plus/minus a day count, run by a small microcoded sequencer.
// Depends on dasd_pkg and date_add_subtract_days_assert.svh.

// One item at a time. After an item is taken, the sequencer reduces the year
// into a 400-year cycle by subtracting 400 per cycle, checks the date (CHECK
// step) and applies the count (PREP step), then walks the date one month per
// cycle until a step sees the walk end, and in its FINISH step, once the
// output register no longer holds an untaken result, writes the result into
// that register. An invalid start date goes from the check straight to the
// FINISH step. A new item is taken the cycle after the result is written,
// even if that result has not yet been taken. A result that is not taken
// holds the next item in its last step. An invalid start date returns error
// code 1, a result beyond years 1..9999 error code 2, both with zeroed date
// fields.
module date_add_subtract_days (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // in_day[4:0], in_month[8:5], in_year[22:9], offset_days[38:23], zero fill
  input  logic [39:0] s_axis_tdata_i,
  // func[0]
  input  logic [0:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // out_day[4:0], out_month[8:5], out_year[22:9], zero fill
  output logic [23:0] m_axis_tdata_o,
  // error_code[1:0]
  output logic [1:0]  m_axis_tuser_o
);

  localparam int unsigned YW = dasd_pkg::YEAR_W;
  localparam int unsigned DW = dasd_pkg::D_W;

  dasd_pkg::step_t  pc_q, pc_d;
  dasd_pkg::ucode_t uw;

  logic                 func_q;
  logic signed [DW-1:0] d_q, d_d;
  logic [3:0]           month_q, month_d;
  logic [YW-1:0]        year_q, year_d;
  logic [YW-1:0]        ycyc_q, ycyc_d;
  logic [dasd_pkg::OFFSET_BITS-1:0] off_q;
  logic [1:0]           err_q, err_d;

  logic                 out_valid_q, out_valid_d;
  logic [4:0]           out_day_q;
  logic [3:0]           out_month_q;
  logic [YW-1:0]        out_year_q;
  logic [1:0]           out_err_q;

  logic                 accept;
  logic                 emit;
  logic                 cond_true;
  logic                 leap_cur;
  logic [4:0]           len_cur;
  logic signed [DW-1:0] len_cur_s;
  logic                 invalid;
  logic                 add_exit;
  logic                 sub_exit;
  logic                 out_full;
  logic [3:0]           month_back;
  logic [YW-1:0]        ycyc_back;
  logic [4:0]           len_back;

  // Fetch the control word
  assign uw = dasd_pkg::ucode_rom(pc_q);

  assign s_axis_tready_o = (uw.act == dasd_pkg::A_LOAD);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_full        = out_valid_q && !m_axis_tready_i;
  assign emit            = (uw.act == dasd_pkg::A_EMIT) && !out_full;

  // Month length of the current month and of the month one step back
  assign leap_cur   = dasd_pkg::is_leap(ycyc_q[8:0]);
  assign len_cur    = dasd_pkg::month_len(month_q, leap_cur);
  assign len_cur_s  = $signed({{(DW-5){1'b0}}, len_cur});
  assign month_back = (month_q == dasd_pkg::MON_JAN) ? dasd_pkg::MON_DEC : month_q - 4'd1;
  assign ycyc_back  = (month_q != dasd_pkg::MON_JAN) ? ycyc_q :
                      (ycyc_q == '0) ? dasd_pkg::CYCLE_LAST : ycyc_q - YW'(1);
  assign len_back   = dasd_pkg::month_len(month_back, dasd_pkg::is_leap(ycyc_back[8:0]));

  // Start date validity; d_q holds the day while checking
  assign invalid = (year_q == '0) || (year_q > dasd_pkg::MAX_YEAR) ||
                   (month_q == '0) || (month_q > dasd_pkg::MON_DEC) ||
                   (d_q == '0) || (d_q > len_cur_s);

  assign add_exit = (err_q != dasd_pkg::ERR_NONE) || (d_q <= len_cur_s);
  assign sub_exit = (err_q != dasd_pkg::ERR_NONE) || (d_q > $signed(DW'(0)));

  // Evaluate the jump condition
  always_comb begin
    case (uw.cond)
      dasd_pkg::C_ALWAYS:     cond_true = 1'b1;
      dasd_pkg::C_NO_INPUT:   cond_true = !s_axis_tvalid_i;
      dasd_pkg::C_CYCLE_DONE: cond_true = (ycyc_q < dasd_pkg::CYCLE_LEN);
      dasd_pkg::C_INVALID:    cond_true = invalid;
      dasd_pkg::C_SUB:        cond_true = func_q;
      dasd_pkg::C_ADD_EXIT:   cond_true = add_exit;
      dasd_pkg::C_SUB_EXIT:   cond_true = sub_exit;
      dasd_pkg::C_OUT_FULL:   cond_true = out_full;
      default:                cond_true = 1'b1;
    endcase
  end

  // Advance the step counter
  always_comb begin
    pc_d = cond_true ? uw.tgt : uw.nxt;
  end

  // Datapath actions
  always_comb begin
    d_d     = d_q;
    month_d = month_q;
    year_d  = year_q;
    ycyc_d  = ycyc_q;
    err_d   = err_q;
    case (uw.act)
      dasd_pkg::A_LOAD: begin
        if (accept) begin
          d_d     = $signed({{(DW-5){1'b0}}, s_axis_tdata_i[4:0]});
          month_d = s_axis_tdata_i[8:5];
          year_d  = s_axis_tdata_i[22:9];
          ycyc_d  = s_axis_tdata_i[22:9];
          err_d   = dasd_pkg::ERR_NONE;
        end
      end
      dasd_pkg::A_REDUCE: begin
        if (ycyc_q >= dasd_pkg::CYCLE_LEN) begin
          ycyc_d = ycyc_q - dasd_pkg::CYCLE_LEN;
        end
      end
      dasd_pkg::A_CHECK: begin
        if (invalid) begin
          err_d = dasd_pkg::ERR_DATE;
        end
      end
      dasd_pkg::A_PREP: begin
        if (func_q) begin
          d_d = d_q - $signed({2'b00, off_q});
        end else begin
          d_d = d_q + $signed({2'b00, off_q});
        end
      end
      dasd_pkg::A_ADD_STEP: begin
        // Drop the current month and carry into the next one
        if (!add_exit) begin
          d_d = d_q - len_cur_s;
          if (month_q == dasd_pkg::MON_DEC) begin
            month_d = dasd_pkg::MON_JAN;
            year_d  = year_q + YW'(1);
            ycyc_d  = (ycyc_q == dasd_pkg::CYCLE_LAST) ? '0 : ycyc_q + YW'(1);
            if (year_q >= dasd_pkg::MAX_YEAR) begin
              err_d = dasd_pkg::ERR_RANGE;
            end
          end else begin
            month_d = month_q + 4'd1;
          end
        end
      end
      dasd_pkg::A_SUB_STEP: begin
        // Borrow the whole previous month
        if (!sub_exit) begin
          month_d = month_back;
          ycyc_d  = ycyc_back;
          d_d     = d_q + $signed({{(DW-5){1'b0}}, len_back});
          if (month_q == dasd_pkg::MON_JAN) begin
            year_d = year_q - YW'(1);
            if (year_q == YW'(1)) begin
              err_d = dasd_pkg::ERR_RANGE;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= dasd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      err_q       <= dasd_pkg::ERR_NONE;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      err_q       <= err_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    d_q     <= d_d;
    month_q <= month_d;
    year_q  <= year_d;
    ycyc_q  <= ycyc_d;
    if (accept) begin
      func_q <= s_axis_tuser_i[0];
      off_q  <= s_axis_tdata_i[38:23];
    end
  end

  // Result register; zero the date on error
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_err_q <= err_q;
      if (err_q != dasd_pkg::ERR_NONE) begin
        out_day_q   <= '0;
        out_month_q <= '0;
        out_year_q  <= '0;
      end else begin
        out_day_q   <= d_q[4:0];
        out_month_q <= month_q;
        out_year_q  <= year_q;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_year_q, out_month_q, out_day_q};
  assign m_axis_tuser_o  = out_err_q;

`include "date_add_subtract_days_assert.svh"

  `DASD_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !m_axis_tvalid_o, "result valid in reset")
  `DASD_ASSERT(a_err_zero_date, m_axis_tvalid_o && (m_axis_tuser_o != dasd_pkg::ERR_NONE) |-> (m_axis_tdata_o == '0), "error result with nonzero date")
  `DASD_ASSERT(a_err_code_legal, m_axis_tvalid_o |-> (m_axis_tuser_o == dasd_pkg::ERR_NONE) || (m_axis_tuser_o == dasd_pkg::ERR_DATE) || (m_axis_tuser_o == dasd_pkg::ERR_RANGE), "illegal error code")
  `DASD_ASSERT(a_ok_date_shape, m_axis_tvalid_o && (m_axis_tuser_o == dasd_pkg::ERR_NONE) |-> (m_axis_tdata_o[4:0] != 5'd0) && (m_axis_tdata_o[8:5] != 4'd0) && (m_axis_tdata_o[8:5] <= dasd_pkg::MON_DEC), "ok result with bad day or month")
  `DASD_ASSERT(a_accept_starts_program, accept |=> (pc_q == dasd_pkg::S_REDUCE), "accepted item did not start the program")

endmodule
